// ===== design/mcg_pkg.sv =====
// Shared constants, types and the queued job record for the midpoint circle generator.
package mcg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CENTER_W     = 12;
    localparam int RADIUS_W     = 11;
    localparam int PIX_W        = 14;
    localparam int DEC_W        = 14;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PIX_PER_STEP = 8;
    localparam int IDX_W        = $clog2(PIX_PER_STEP);
    localparam int OFF_EXT_W    = (COORD_BITS + 1 > DEC_W) ? COORD_BITS + 1 : DEC_W;
    localparam int SUM_W        = (COORD_BITS + 2 > PIX_W) ? COORD_BITS + 2 : PIX_W;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] off_x;
        logic [COORD_BITS-1:0] off_y;
        logic                  done;
    } job_t;

endpackage

// ===== design/mcg_front.sv =====
// Front end: accepts items, holds circle state and runs one midpoint iteration per step.
module mcg_front
    import mcg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [CENTER_W-1:0] s_center_x,
    input  logic [CENTER_W-1:0] s_center_y,
    input  logic [RADIUS_W-1:0] s_radius,
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_data
);

    logic [COORD_BITS-1:0] offset_x_reg, offset_x_next;
    logic [COORD_BITS-1:0] offset_y_reg, offset_y_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;
    logic [COORD_BITS-1:0] center_x_reg, center_x_next;
    logic [COORD_BITS-1:0] center_y_reg, center_y_next;

    logic                  accept;
    logic                  active;
    logic [COORD_BITS-1:0] x_new;
    logic [COORD_BITS-1:0] y_new;
    logic [COORD_BITS-1:0] r_in;
    logic [OFF_EXT_W-1:0]  two_x;
    logic [OFF_EXT_W-1:0]  two_y;
    logic [DEC_W-1:0]      dec_step;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign active  = offset_x_reg < offset_y_reg;
    assign r_in    = COORD_BITS'(s_radius);

    always_comb begin
        x_new = offset_x_reg + COORD_BITS'(1);
        y_new = decision_reg[DEC_W-1] ? offset_y_reg : offset_y_reg - COORD_BITS'(1);
        two_x = OFF_EXT_W'({x_new, 1'b0});
        two_y = OFF_EXT_W'({y_new, 1'b0});
        dec_step = decision_reg + two_x[DEC_W-1:0] + DEC_W'(1);
        if (!decision_reg[DEC_W-1]) begin
            dec_step = dec_step - two_y[DEC_W-1:0];
        end

        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        q_push        = 1'b0;

        if (accept) begin
            if (s_kind == KIND_START) begin
                center_x_next = COORD_BITS'(s_center_x);
                center_y_next = COORD_BITS'(s_center_y);
                offset_x_next = '0;
                offset_y_next = r_in;
                decision_next = DEC_W'(1) - DEC_W'(r_in);
            end else if (active) begin
                offset_x_next = x_new;
                offset_y_next = y_new;
                decision_next = dec_step;
                q_push        = 1'b1;
            end
        end

        q_data.center_x = center_x_reg;
        q_data.center_y = center_y_reg;
        q_data.off_x    = x_new;
        q_data.off_y    = y_new;
        q_data.done     = x_new >= y_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            decision_reg <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else begin
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            decision_reg <= decision_next;
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

endmodule

// ===== design/mcg_queue.sv =====
// Short job queue between the front end and the pixel emitter.
module mcg_queue
    import mcg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/mcg_back.sv =====
// Back end: emits the eight symmetric pixels of each queued iteration, one per cycle while m_ready does not stall it.
module mcg_back
    import mcg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    input  job_t                    job,
    output logic                    job_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_pixel_x,
    output logic signed [PIX_W-1:0] m_pixel_y,
    output logic                    m_last_of_step,
    output logic                    m_circle_done
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIX_PER_STEP - 1);

    logic                    m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [PIX_W-1:0] pixel_x_reg;
    logic signed [PIX_W-1:0] pixel_y_reg;
    logic                    last_reg;
    logic                    done_reg;

    logic                    load;
    logic                    take;
    logic [SUM_W-1:0]        a_ext;
    logic [SUM_W-1:0]        b_ext;
    logic [SUM_W-1:0]        dx;
    logic [SUM_W-1:0]        dy;
    logic [SUM_W-1:0]        sum_x;
    logic [SUM_W-1:0]        sum_y;

    assign load = !m_valid_reg || m_ready;
    assign take = load && job_valid;

    always_comb begin
        a_ext = idx_reg[2] ? SUM_W'(job.off_y) : SUM_W'(job.off_x);
        b_ext = idx_reg[2] ? SUM_W'(job.off_x) : SUM_W'(job.off_y);
        dx    = idx_reg[1] ? -a_ext : a_ext;
        dy    = idx_reg[0] ? -b_ext : b_ext;
        sum_x = SUM_W'(job.center_x) + dx;
        sum_y = SUM_W'(job.center_y) + dy;

        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        job_pop      = 1'b0;
        if (load) begin
            m_valid_next = job_valid;
        end
        if (take) begin
            idx_next = idx_reg + IDX_W'(1);
            job_pop  = idx_reg == LAST_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pixel_x_reg <= sum_x[PIX_W-1:0];
            pixel_y_reg <= sum_y[PIX_W-1:0];
            last_reg    <= idx_reg == LAST_IDX;
            done_reg    <= job.done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = pixel_x_reg;
    assign m_pixel_y      = pixel_y_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

endmodule

// ===== design/midpoint_circle_generator.sv =====
// Midpoint circle generator top level: front end, job queue and pixel emitter.
// A step item is written into the job queue, and its first pixel then into the output register
// once the output is free.
// Step items drain at the single pixel output port's rate (one pixel/cycle unless m_ready stalls it).
// Start items and steps after the end are accepted without a queue entry and emit nothing.
// Reset: synchronous, active low; clears offsets, decision, held center, queue and output.
module midpoint_circle_generator
    import mcg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [CENTER_W-1:0]     s_center_x,
    input  logic [CENTER_W-1:0]     s_center_y,
    input  logic [RADIUS_W-1:0]     s_radius,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_pixel_x,
    output logic signed [PIX_W-1:0] m_pixel_y,
    output logic                    m_last_of_step,
    output logic                    m_circle_done
);

    logic q_full;
    logic q_push;
    job_t q_data;
    logic q_pop;
    logic head_valid;
    job_t head_data;

    mcg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    mcg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mcg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (head_valid),
        .job            (head_data),
        .job_pop        (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_step_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_step) |=>
            (m_valid && (m_circle_done == $past(m_circle_done))))
        else $error("iteration broken before its last pixel");

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (m_valid && m_last_of_step))
        else $error("job released without its last pixel");
`endif

endmodule
